/* rtl/core/lphd_pkg.sv */
// Shared types and constants for the linear-probe hash dictionary.
// Used by the hash unit and the top-level controller; depends on nothing.
package lphd_pkg;

   // Field widths
   localparam int KEY_LOW_W  = 64;
   localparam int KEY_HIGH_W = 16;
   localparam int ID_W       = 12;
   localparam int CFG_W      = 4;
   localparam int STATUS_W   = 2;

   // Reset value of the table size register (log2 of slots)
   localparam logic [CFG_W-1:0] TABLE_LG_RESET = 4'd12;

   // Request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Mix constants
   localparam logic [63:0] MIX_MUL1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL2   = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT  = 33;
   localparam int          KEY_ROT    = 17;

   // One table slot as stored in memory
   typedef struct packed {
      logic                  valid;
      logic [ID_W-1:0]       id;
      logic [KEY_HIGH_W-1:0] key_high;
      logic [KEY_LOW_W-1:0]  key_low;
   } lphd_entry_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_CHECK,
      ST_DONE
   } lphd_state_type;

endpackage

/* rtl/core/lphd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module lphd_ram #(
   parameter int WIDTH = 93,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lphd_hash.sv */
// Multi-cycle 64-bit key mix: xor-shift, multiply, xor-shift, multiply, xor-shift.
// Uses lphd_pkg for mix constants; one shared 32x32 multiplier forms all partial products.
module lphd_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lphd_pkg::KEY_LOW_W-1:0]  key_low,
   input  logic [lphd_pkg::KEY_HIGH_W-1:0] key_high,
   output logic                           done,
   output logic [63:0]                    hash
);
   import lphd_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic        round_ff, round_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;

   logic [63:0] mix_x;
   logic [63:0] mul_c;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_res;
   logic [63:0] acc_sum;

   // Fold the high key part in, rotated (its top bits never wrap)
   assign mix_x = key_low ^ (64'(key_high) << KEY_ROT);

   // Pick partial-product operands for this step
   assign mul_c = round_ff ? MIX_MUL2 : MIX_MUL1;
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = v_ff[31:0];
            mul_b = mul_c[31:0];
         end
         2'd1: begin
            mul_a = v_ff[31:0];
            mul_b = mul_c[63:32];
         end
         default: begin
            mul_a = v_ff[63:32];
            mul_b = mul_c[31:0];
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;
   assign acc_sum = acc_ff + {prod_ff[31:0], 32'd0};

   // Sequence: issue low*low, low*high, high*low; accumulate each product from its register
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      round_in = round_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 2'd0;
         round_in = 1'b0;
         v_in     = mix_x ^ (mix_x >> MIX_SHIFT);
      end else if (busy_ff) begin
         prod_in = mul_res;
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd1: begin
               acc_in = prod_ff;
            end
            2'd2: begin
               acc_in = acc_sum;
            end
            2'd3: begin
               v_in = acc_sum ^ (acc_sum >> MIX_SHIFT);
               if (round_ff) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  round_in = 1'b1;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      round_ff <= round_in;
      v_ff     <= v_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
   end

   assign done = done_ff;
   assign hash = v_ff;

endmodule

/* rtl/core/linear_probe_hash_dictionary_unit.sv */
// Linear-probe hash dictionary: maps 80-bit keys to sequential 12-bit ids. After reset the
// unit sweeps the slot memory to clear the valid bits and takes no request meanwhile (size
// writes are taken). Each request then passes through acceptance, the key mix on one shared
// 32x32 multiplier, the issue of the home-slot read, one registered read of the slot memory
// per slot probed, and the hand-over of the response; no new request is accepted until the
// last one is handed over. The response register holds a result while the next request is
// accepted; a request that finishes while that result still waits stalls until it is taken.
// Depends on lphd_pkg, lphd_ram, lphd_hash.
module linear_probe_hash_dictionary_unit #(
   parameter int SLOTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lphd_pkg::CFG_W-1:0]      csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [lphd_pkg::KEY_LOW_W-1:0]  req_key_low,
   input  logic [lphd_pkg::KEY_HIGH_W-1:0] req_key_high,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lphd_pkg::ID_W-1:0]       rsp_found_id,
   output logic [lphd_pkg::STATUS_W-1:0]   rsp_status
);
   import lphd_pkg::*;

   localparam int ADDR_W = $clog2(SLOTS);
   localparam int MAX_LG = $clog2(SLOTS + 1) - 1;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOTS - 1);

   lphd_state_type state_ff, state_in;

   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [CFG_W-1:0]      lg_ff;
   logic                  op_ff, op_in;
   logic [KEY_LOW_W-1:0]  key_low_ff, key_low_in;
   logic [KEY_HIGH_W-1:0] key_high_ff, key_high_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     count_ff, count_in;
   logic [ID_W-1:0]       ins_count_ff, ins_count_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_load;

   logic [ADDR_W-1:0] mask_c;
   logic [ADDR_W-1:0] home_addr;
   logic [ADDR_W-1:0] next_addr;

   logic                  hash_start;
   logic                  hash_done;
   logic [63:0]           hash_value;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   lphd_entry_type        wr_entry;
   logic [ADDR_W-1:0]     rd_addr;
   lphd_entry_type        rd_entry;

   logic slot_empty;
   logic key_match;
   logic last_probe;
   logic probe_end;

   // Probe mask from the size register, capped to the memory size
   always_comb begin
      for (int i = 0; i < ADDR_W; i++) begin
         mask_c[i] = (i < int'(lg_ff)) && (i < MAX_LG);
      end
   end

   assign home_addr = hash_value[ADDR_W-1:0] & mask_c;
   assign next_addr = (addr_ff + ADDR_W'(1)) & mask_c;

   // Slot checks on the entry read last cycle
   assign slot_empty = !rd_entry.valid;
   assign key_match  = (rd_entry.key_low == key_low_ff) && (rd_entry.key_high == key_high_ff);
   assign last_probe = (count_ff == mask_c);
   assign probe_end  = (op_ff == OP_INSERT) ? (slot_empty || last_probe)
                                            : (slot_empty || key_match || last_probe);

   assign hash_start = req_valid && req_ready;

   lphd_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key_low  (req_key_low),
      .key_high (req_key_high),
      .done     (hash_done),
      .hash     (hash_value)
   );

   lphd_ram #(
      .WIDTH ($bits(lphd_entry_type)),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (probe_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: memory access, probe advance, result capture
   always_comb begin
      req_ready     = 1'b0;
      clr_in        = clr_ff;
      rd_addr       = next_addr;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_entry      = '{valid: 1'b1, id: ins_count_ff, key_high: key_high_ff,
                        key_low: key_low_ff};
      op_in         = op_ff;
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      ins_count_in  = ins_count_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep one slot per cycle, marking it empty
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_entry = '0;
            clr_in   = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_operation;
               key_low_in  = req_key_low;
               key_high_in = req_key_high;
            end
         end
         ST_HASH: begin
            // Read the home slot as soon as the mix is ready
            rd_addr  = home_addr;
            addr_in  = home_addr;
            count_in = '0;
         end
         ST_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (slot_empty) begin
                  wr_en         = 1'b1;
                  res_id_in     = ins_count_ff;
                  res_status_in = STATUS_OK;
                  ins_count_in  = ins_count_ff + ID_W'(1);
               end else begin
                  res_id_in     = '0;
                  res_status_in = STATUS_FULL;
               end
            end else begin
               if (!slot_empty && key_match) begin
                  res_id_in     = rd_entry.id;
                  res_status_in = STATUS_OK;
               end else begin
                  res_id_in     = '0;
                  res_status_in = STATUS_NOT_FOUND;
               end
            end
            // Advance to the next slot; its read is already issued
            if (!probe_end) begin
               addr_in  = next_addr;
               count_in = count_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lg_ff        <= TABLE_LG_RESET;
         ins_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ins_count_ff <= ins_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            lg_ff <= csr_wr_data;
         end
      end
      op_ff         <= op_in;
      key_low_ff    <= key_low_in;
      key_high_ff   <= key_high_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_id_ff     <= res_id_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found_id = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;

   // Memory is written only by the clearing sweep or a successful insert
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_CHECK))
      else $error("slot write outside clear or probe");

   // Probe position and count stay inside the table in use
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> ((addr_ff & ~mask_c) == '0 && (count_ff & ~mask_c) == '0))
      else $error("probe outside table");

   // The mix completes only while the controller waits for it
   a_hash_sync: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH)
      else $error("hash done while not waiting");

   // A successful insert advances the id counter by one
   a_id_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && op_ff == OP_INSERT && slot_empty)
      |=> ins_count_ff == $past(ins_count_ff) + ID_W'(1))
      else $error("id counter did not advance");

   // Handing over a result raises the response valid
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("response not presented");

endmodule

/* test/linear_probe_hash_dictionary_checker.sv */
// Reply checker for the linear-probe hash dictionary: mirrors the slot table, predicts
// each reply from the accepted requests and compares it. Depends on lphd_pkg.
module linear_probe_hash_dictionary_checker #(
   parameter int SLOTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lphd_pkg::CFG_W-1:0]      csr_wr_data,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_operation,
   input  logic [lphd_pkg::KEY_LOW_W-1:0]  req_key_low,
   input  logic [lphd_pkg::KEY_HIGH_W-1:0] req_key_high,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [lphd_pkg::ID_W-1:0]       rsp_found_id,
   input  logic [lphd_pkg::STATUS_W-1:0]   rsp_status,
   output int                              fail_count,
   output int                              outstanding,
   output int                              found_count,
   output int                              missing_count,
   output int                              full_count
);
   import lphd_pkg::*;

   localparam int IDX_W     = $clog2(SLOTS);
   localparam int SHOWN_MAX = 10;

   typedef struct packed {
      logic [ID_W-1:0]     found_id;
      logic [STATUS_W-1:0] status;
   } dict_reply_type;

   // Mirror of the slot table, the id counter and the size register
   logic [KEY_LOW_W-1:0]  slot_lo   [SLOTS];
   logic [KEY_HIGH_W-1:0] slot_hi   [SLOTS];
   logic [ID_W-1:0]       slot_id   [SLOTS];
   bit                    slot_used [SLOTS];
   logic [ID_W:0]         inserts_done;
   logic [CFG_W-1:0]      size_lg;

   dict_reply_type expected_replies [$];
   int             mismatches = 0;
   int             hits = 0;
   int             misses = 0;
   int             fulls = 0;
   int             reply_number = 0;

   // 64-bit finalizer mix of the folded key
   function automatic logic [63:0] fmix_key(input logic [KEY_LOW_W-1:0] lo,
                                            input logic [KEY_HIGH_W-1:0] hi);
      logic [63:0] wide_hi;
      logic [63:0] v;
      wide_hi = {48'd0, hi};
      v = lo ^ ((wide_hi << KEY_ROT) | (wide_hi >> (64 - KEY_ROT)));
      v = v ^ (v >> MIX_SHIFT);
      v = v * MIX_MUL1;
      v = v ^ (v >> MIX_SHIFT);
      v = v * MIX_MUL2;
      v = v ^ (v >> MIX_SHIFT);
      return v;
   endfunction

   // Probe the mirror table for one request and update it on insert
   function automatic dict_reply_type predict_reply(input logic op,
                                                    input logic [KEY_LOW_W-1:0] lo,
                                                    input logic [KEY_HIGH_W-1:0] hi);
      dict_reply_type   reply;
      logic [IDX_W-1:0] mask;
      logic [IDX_W-1:0] slot;
      logic [63:0]      hash;
      int               lg;
      bit               done;
      // saturate the size to the store
      lg = 0;
      while (lg < int'(size_lg) && (2 << lg) <= SLOTS) lg++;
      mask = {IDX_W{1'b1}} >> (IDX_W - lg);
      hash = fmix_key(lo, hi);
      slot = hash[IDX_W-1:0] & mask;
      reply.found_id = '0;
      reply.status = (op == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      done = 1'b0;
      for (int n = 0; n < (1 << lg) && !done; n++) begin
         if (op == OP_INSERT) begin
            if (!slot_used[slot]) begin
               slot_used[slot] = 1'b1;
               slot_lo[slot] = lo;
               slot_hi[slot] = hi;
               slot_id[slot] = inserts_done[ID_W-1:0];
               reply.found_id = inserts_done[ID_W-1:0];
               reply.status = STATUS_OK;
               inserts_done = inserts_done + 1'b1;
               done = 1'b1;
            end
         end else if (!slot_used[slot]) begin
            done = 1'b1;
         end else if (slot_lo[slot] == lo && slot_hi[slot] == hi) begin
            reply.found_id = slot_id[slot];
            reply.status = STATUS_OK;
            done = 1'b1;
         end
         slot = (slot + 1'b1) & mask;
      end
      return reply;
   endfunction

   // Track requests and replies at each edge
   always @(posedge clock) begin : watch_channels
      dict_reply_type want;
      dict_reply_type got;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         inserts_done = '0;
         size_lg = TABLE_LG_RESET;
         expected_replies.delete();
      end else begin
         if (csr_wr_en) begin
            size_lg = csr_wr_data;
         end
         // predict the reply of an accepted request
         if (req_valid && req_ready) begin
            want = predict_reply(req_operation, req_key_low, req_key_high);
            expected_replies = {expected_replies, want};
            if (want.status == STATUS_OK) hits++;
            else if (want.status == STATUS_NOT_FOUND) misses++;
            else fulls++;
         end
         // compare an accepted reply with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.found_id = rsp_found_id;
            got.status = rsp_status;
            reply_number++;
            if (expected_replies.size() == 0) begin
               if (mismatches < SHOWN_MAX) begin
                  $display("reply %0d: unexpected, found_id %0d status %0d",
                           reply_number, got.found_id, got.status);
               end
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (got.found_id !== want.found_id || got.status !== want.status) begin
                  if (mismatches < SHOWN_MAX) begin
                     $display("reply %0d: found_id %0d expected %0d, status %0d expected %0d",
                              reply_number, got.found_id, want.found_id,
                              got.status, want.status);
                  end
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      outstanding <= expected_replies.size();
      found_count <= hits;
      missing_count <= misses;
      full_count <= fulls;
   end

endmodule

/* test/linear_probe_hash_dictionary_unit_test.sv */
// Testbench top for the linear-probe hash dictionary: clock, reset, request and reply
// traffic, size settings and the verdict. Depends on lphd_pkg, the unit and its checker.
module linear_probe_hash_dictionary_unit_test;
   import lphd_pkg::*;

   localparam int SLOTS       = 4096;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int KNOWN_MAX   = 1024;

   typedef struct packed {
      logic [KEY_LOW_W-1:0]  lo;
      logic [KEY_HIGH_W-1:0] hi;
   } dict_key_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_INSERT;
   logic [KEY_LOW_W-1:0]  req_key_low = '0;
   logic [KEY_HIGH_W-1:0] req_key_high = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ID_W-1:0]       rsp_found_id;
   logic [STATUS_W-1:0]   rsp_status;

   int fail_count;
   int outstanding;
   int found_count;
   int missing_count;
   int full_count;

   int           accepted_requests = 0;
   int           hold_left = 0;
   int           next_hold_at = 400;
   int           cycle_count = 0;
   dict_key_type known_keys [$];

   linear_probe_hash_dictionary_unit #(.SLOTS(SLOTS)) uut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_key_low  (req_key_low),
      .req_key_high (req_key_high),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found_id (rsp_found_id),
      .rsp_status   (rsp_status)
   );

   linear_probe_hash_dictionary_checker #(.SLOTS(SLOTS)) reply_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_key_low  (req_key_low),
      .req_key_high (req_key_high),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found_id (rsp_found_id),
      .rsp_status   (rsp_status),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .found_count  (found_count),
      .missing_count(missing_count),
      .full_count   (full_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle rates: sender light then heavy, then no idling at all
   function automatic int sender_idle_pct(input int n);
      if (n < 550) return 31;
      else if (n < 1100) return 77;
      return 0;
   endfunction

   function automatic int receiver_idle_pct(input int n);
      if (n < 550) return 77;
      else if (n < 1100) return 31;
      return 0;
   endfunction

   // Reply side: random stalls plus two long hold-offs to back up the unit
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (accepted_requests >= next_hold_at) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         next_hold_at <= next_hold_at + 900;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(accepted_requests));
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(input logic op, input logic [KEY_LOW_W-1:0] lo,
                               input logic [KEY_HIGH_W-1:0] hi);
      while ($urandom_range(99) < sender_idle_pct(accepted_requests)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_low <= lo;
      req_key_high <= hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_requests <= accepted_requests + 1;
   endtask

   // Drop valid and wait until every predicted reply is back
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_table_size(input logic [CFG_W-1:0] lg);
      wait_for_replies();
      csr_wr_en <= 1'b1;
      csr_wr_data <= lg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic dict_key_type pick_known();
      return known_keys[$urandom_range(known_keys.size() - 1)];
   endfunction

   // New key: mostly random, some extremes, some one bit away from a stored key
   function automatic dict_key_type fresh_key();
      dict_key_type k;
      logic [31:0]  r;
      int           pick;
      int           b;
      pick = $urandom_range(99);
      r = $urandom;
      k.lo = {$urandom, $urandom};
      k.hi = r[15:0];
      if (pick < 8) begin
         k.lo = r[16] ? '1 : '0;
         k.hi = r[17] ? '1 : '0;
      end else if (pick < 30 && known_keys.size() > 0) begin
         k = pick_known();
         b = $urandom_range(KEY_LOW_W + KEY_HIGH_W - 1);
         if (b < KEY_LOW_W) k.lo[b] = ~k.lo[b];
         else k.hi[b - KEY_LOW_W] = ~k.hi[b - KEY_LOW_W];
      end
      return k;
   endfunction

   // One random request: inserts, lookups of stored keys, lookups of new keys
   task automatic random_request();
      dict_key_type k;
      int           r;
      r = $urandom_range(99);
      if (r < 45) begin
         k = (r < 6 && known_keys.size() > 0) ? pick_known() : fresh_key();
         send_request(OP_INSERT, k.lo, k.hi);
         if (known_keys.size() < KNOWN_MAX) known_keys = {known_keys, k};
         else known_keys[$urandom_range(KNOWN_MAX - 1)] = k;
      end else if (r < 80 && known_keys.size() > 0) begin
         k = pick_known();
         send_request(OP_LOOKUP, k.lo, k.hi);
      end else begin
         k = fresh_key();
         send_request(OP_LOOKUP, k.lo, k.hi);
      end
   endtask

   task automatic run_random_phase(input logic [CFG_W-1:0] lg, input int count);
      set_table_size(lg);
      repeat (count) random_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset size: extreme keys, duplicate insert, keys differing in one half
      send_request(OP_INSERT, 64'h0, 16'h0);
      send_request(OP_INSERT, '1, '1);
      send_request(OP_LOOKUP, 64'h0, 16'h0);
      send_request(OP_LOOKUP, '1, '1);
      send_request(OP_INSERT, '1, '1);
      send_request(OP_LOOKUP, '1, '1);
      send_request(OP_LOOKUP, '1, 16'h0);
      send_request(OP_LOOKUP, 64'h0, '1);
      send_request(OP_INSERT, 64'h8000_0000_0000_0000, 16'h8000);

      // One slot: the zero key sits there, so insert reports full
      set_table_size(4'd0);
      send_request(OP_INSERT, 64'h1, 16'h0);
      send_request(OP_LOOKUP, 64'h0, 16'h0);
      send_request(OP_LOOKUP, 64'h5, 16'h5);

      // Two slots: fill, overflow, then look up through a full table
      set_table_size(4'd1);
      send_request(OP_INSERT, 64'h0123_4567_89ab_cdef, 16'h1357);
      send_request(OP_INSERT, 64'hfedc_ba98_7654_3210, 16'h2468);
      send_request(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 16'h1357);
      send_request(OP_LOOKUP, 64'hfedc_ba98_7654_3210, 16'h2468);

      // Oversized setting saturates; old entries are reached again
      set_table_size(4'd15);
      send_request(OP_LOOKUP, 64'h0, 16'h0);
      send_request(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 16'h1357);
      send_request(OP_INSERT, 64'h0, 16'h0);

      // Random traffic across small, full-size and oversized tables
      run_random_phase(4'd3, 60);
      run_random_phase(4'd12, 500);
      run_random_phase(4'd5, 120);
      run_random_phase(4'd15, 400);
      run_random_phase(4'd2, 40);
      run_random_phase(4'd13, 300);
      run_random_phase(4'd8, 100);
      run_random_phase(4'd14, 80);

      // Drain, let the unit settle, then report
      wait_for_replies();
      repeat (64) @(posedge clock);
      $display("Ran %0d requests over ten table sizes from one slot to oversized settings",
               accepted_requests);
      $display("Replies predicted: %0d hits, %0d not found, %0d table full",
               found_count, missing_count, full_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
